FILE: src/mbps_pkg.sv
package mbps_pkg;

  localparam int DEF_MAX_PATTERN_BYTES = 64;
  localparam int DEF_OFFSET_BITS       = 32;

  localparam int BYTE_W      = 8;
  localparam int OUT_OFF_W   = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_DATA    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [OUT_OFF_W-1:0] out_off_t;

endpackage

FILE: src/mbps_in_if.sv
interface mbps_in_if;
  import mbps_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  byte_t byte_value;
  byte_t byte_mask;

  modport source (output valid, output func, output byte_value, output byte_mask,
                  input ready);
  modport sink   (input valid, input func, input byte_value, input byte_mask,
                  output ready);
endinterface

FILE: src/mbps_out_if.sv
interface mbps_out_if;
  import mbps_pkg::*;

  logic     valid;
  logic     ready;
  logic     match_now;
  logic     found;
  out_off_t first_offset;
  logic     overflow;

  modport source (output valid, output match_now, output found, output first_offset,
                  output overflow, input ready);
  modport sink   (input valid, input match_now, input found, input first_offset,
                  input overflow, output ready);
endinterface

FILE: src/masked_byte_pattern_search_core.sv
// Channel  Dir  Handshake      Payload
// item     in   valid/ready    func, byte_value, byte_mask
// result   out  valid/ready    match_now, found, first_offset, overflow
//
// One result beat per item beat; a new item is taken every clock cycle while the result side is not stalled.
// The path runs through the input register, then one compare pass over all
// pattern positions in parallel into the result register.
// Reset (rst, synchronous) empties the pattern, zeroes the byte count and the
// found flag, and drops any beat in flight.
// A stalled result holds; the input register still fills behind it.
module masked_byte_pattern_search_core #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int OFFSET_BITS       = mbps_pkg::DEF_OFFSET_BITS
) (
  input  logic              clk,
  input  logic              rst,
  mbps_in_if.sink           item,
  mbps_out_if.source        result
);
  import mbps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CMP_W = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LEN_W-1:0]       len_t;

  // input register
  logic  s1_valid;
  func_t s1_func;
  byte_t s1_value;
  byte_t s1_mask;

  // pattern, stored by age: entry 0 pairs with the newest data byte
  byte_t pat_val [MAX_PATTERN_BYTES];
  byte_t pat_msk [MAX_PATTERN_BYTES];
  len_t  plen;
  len_t  plen_next;

  // data window, entry 0 is the newest byte
  byte_t win [MAX_PATTERN_BYTES];

  offset_t bytes_seen;
  offset_t bytes_seen_next;
  logic    found_flag;
  logic    found_flag_next;
  offset_t first_off;
  offset_t first_off_next;

  // result register
  logic     o_valid;
  logic     o_match;
  logic     o_found;
  out_off_t o_offset;
  logic     o_ovf;

  logic    adv;
  logic    fire;
  logic    full;
  logic    do_append;
  logic    do_data;
  byte_t   cand [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hit;
  offset_t seen_inc;
  logic    long_enough;
  logic    match;
  logic    ovf;
  offset_t start;

  assign adv         = !o_valid || result.ready;
  assign fire        = s1_valid && adv;
  assign item.ready  = !s1_valid || adv;
  assign full        = (plen == LEN_W'(MAX_PATTERN_BYTES));
  assign do_append   = fire && (s1_func == FUNC_APPEND) && !full;
  assign do_data     = fire && (s1_func == FUNC_DATA);

  always_comb begin
    cand[0] = s1_value;
    for (int a = 1; a < MAX_PATTERN_BYTES; a++) begin
      cand[a] = win[a-1];
    end
    for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
      hit[a] = (LEN_W'(a) >= plen) || ((cand[a] & pat_msk[a]) == pat_val[a]);
    end
  end

  assign seen_inc    = (bytes_seen == '1) ? bytes_seen : bytes_seen + 1'b1;
  assign long_enough = CMP_W'(seen_inc) >= CMP_W'(plen);

  always_comb begin
    plen_next       = plen;
    bytes_seen_next = bytes_seen;
    found_flag_next = found_flag;
    first_off_next  = first_off;
    match           = 1'b0;
    ovf             = 1'b0;
    start           = '0;
    case (s1_func)
      FUNC_CLEAR: begin
        plen_next = '0;
      end
      FUNC_APPEND: begin
        if (full) begin
          ovf = 1'b1;
        end else begin
          plen_next = plen + 1'b1;
        end
      end
      FUNC_DATA: begin
        bytes_seen_next = seen_inc;
        if (plen == '0) begin
          match = 1'b1;
        end else if (long_enough && (&hit)) begin
          match = 1'b1;
          // plen <= seen_inc here, so the truncation keeps its value
          start = seen_inc - OFFSET_BITS'(plen);
        end
        if (match && !found_flag) begin
          found_flag_next = 1'b1;
          first_off_next  = start;
        end
      end
      FUNC_RESTART: begin
        bytes_seen_next = '0;
        found_flag_next = 1'b0;
        first_off_next  = '0;
      end
      default: begin
        plen_next = plen;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (item.valid && item.ready) begin
      s1_func  <= item.func;
      s1_value <= item.byte_value;
      s1_mask  <= item.byte_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen       <= '0;
      bytes_seen <= '0;
      found_flag <= 1'b0;
      first_off  <= '0;
    end else if (fire) begin
      plen       <= plen_next;
      bytes_seen <= bytes_seen_next;
      found_flag <= found_flag_next;
      first_off  <= first_off_next;
    end
  end

  // shift the pattern by age on append, the window on each data byte
  always_ff @(posedge clk) begin
    if (do_append) begin
      pat_val[0] <= s1_value;
      pat_msk[0] <= s1_mask;
      for (int a = 1; a < MAX_PATTERN_BYTES; a++) begin
        pat_val[a] <= pat_val[a-1];
        pat_msk[a] <= pat_msk[a-1];
      end
    end
    if (do_data) begin
      for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
        win[a] <= cand[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
    if (fire) begin
      o_match  <= match;
      o_found  <= found_flag_next;
      o_offset <= found_flag_next ? OUT_OFF_W'(first_off_next) : '0;
      o_ovf    <= ovf;
    end
  end

  assign result.valid        = o_valid;
  assign result.match_now    = o_match;
  assign result.found        = o_found;
  assign result.first_offset = o_offset;
  assign result.overflow     = o_ovf;

endmodule

FILE: src/mbps_checker.sv
module mbps_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     match_now,
  input logic                     found,
  input mbps_pkg::out_off_t       first_offset,
  input logic                     overflow
);
  import mbps_pkg::*;

  // no beat may appear in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_now) && $stable(found)
      && $stable(first_offset) && $stable(overflow))
    else $error("stalled result changed");

  a_match_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_now |-> found)
    else $error("match without found");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> first_offset == '0)
    else $error("offset nonzero while not found");

  a_match_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(match_now && overflow))
    else $error("match and overflow on one beat");

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .match_now    (result.match_now),
  .found        (result.found),
  .first_offset (result.first_offset),
  .overflow     (result.overflow)
);

FILE: dv/masked_byte_pattern_search_core_test.sv
module masked_byte_pattern_search_core_test;
  import mbps_pkg::*;

  localparam int PAT_DEPTH = DEF_MAX_PATTERN_BYTES;
  localparam int CNT_W     = DEF_OFFSET_BITS;

  typedef struct packed {
    logic     match_now;
    logic     found;
    out_off_t first_offset;
    logic     overflow;
  } search_result_t;

  logic clk;
  logic rst;

  mbps_in_if  item_ch ();
  mbps_out_if result_ch ();

  masked_byte_pattern_search_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Predicted block state
  byte_t             pat_val [PAT_DEPTH];
  byte_t             pat_mask [PAT_DEPTH];
  int unsigned       pat_len;
  byte_t             recent [PAT_DEPTH];  // recent[0] is the newest data byte
  logic [CNT_W-1:0]  scan_count;
  logic              hit_seen;
  logic [CNT_W-1:0]  hit_offset;

  search_result_t pending_results[$];

  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned match_beats;
  int unsigned overflow_beats;
  int unsigned mismatch_count;
  int unsigned hold_request;
  bit          sender_idle_on;
  bit          receiver_idle_on;

  always #5 clk = ~clk;

  // Work out the result of one accepted beat and queue it.
  function automatic void predict_search(func_t f, byte_t v, byte_t m);
    search_result_t r;
    logic [CNT_W-1:0] start;
    logic hit;
    r = '0;
    case (f)
      FUNC_CLEAR: pat_len = 0;
      FUNC_APPEND: begin
        if (pat_len >= PAT_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          pat_val[pat_len]  = v;
          pat_mask[pat_len] = m;
          pat_len++;
        end
      end
      FUNC_DATA: begin
        for (int k = PAT_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = v;
        if (scan_count != '1) scan_count++;
        hit = 1'b0;
        start = '0;
        if (pat_len == 0) begin
          hit = 1'b1;
        end else if (scan_count >= pat_len) begin
          hit = 1'b1;
          for (int i = 0; i < pat_len; i++)
            if ((recent[pat_len-1-i] & pat_mask[i]) != pat_val[i]) hit = 1'b0;
          if (hit) start = scan_count - pat_len;
        end
        if (hit && !hit_seen) begin
          hit_seen   = 1'b1;
          hit_offset = start;
        end
        r.match_now = hit;
      end
      default: begin
        scan_count = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
      end
    endcase
    r.found        = hit_seen;
    r.first_offset = hit_seen ? out_off_t'(hit_offset) : '0;
    pending_results.push_back(r);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  task automatic send_beat(input func_t f, input byte_t v, input byte_t m);
    int unsigned gap;
    item_ch.valid      <= 1'b1;
    item_ch.func       <= f;
    item_ch.byte_value <= v;
    item_ch.byte_mask  <= m;
    do begin
      @(posedge clk);
    end while (!item_ch.ready);
    predict_search(f, v, m);
    items_sent++;
    @(negedge clk);
    gap = sender_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop the offer, then wait until every predicted beat has come out.
  task automatic wait_for_drain();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Output side: random stalls, plus a long hold when a test asks for one.
  initial begin
    int unsigned n;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      n = receiver_idle_on ? idle_len() : 0;
      if (n != 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    search_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: extra beat: expected none, actual %0b %0b %0h %0b",
                 $time, result_ch.match_now, result_ch.found, result_ch.first_offset,
                 result_ch.overflow);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (want.match_now) match_beats++;
        if (want.overflow) overflow_beats++;
        check_field("match_now", want.match_now, result_ch.match_now);
        check_field("found", want.found, result_ch.found);
        check_field("first_offset", want.first_offset, result_ch.first_offset);
        check_field("overflow", want.overflow, result_ch.overflow);
      end
    end
  end

  // Empty pattern matches every data byte at offset zero.
  task automatic test_empty_pattern();
    send_beat(FUNC_DATA, 8'h00, 8'h00);
    send_beat(FUNC_DATA, 8'hFF, 8'hFF);
    send_beat(FUNC_CLEAR, 8'hFF, 8'hFF);
    send_beat(FUNC_RESTART, 8'h00, 8'hFF);
    send_beat(FUNC_APPEND, 8'h5A, 8'hFF);
    send_beat(FUNC_CLEAR, 8'h00, 8'h00);
  endtask

  // Exact, wildcard and partial masks; a value bit outside its mask never matches.
  task automatic test_masked_compare();
    send_beat(FUNC_RESTART, 8'h00, 8'h00);
    send_beat(FUNC_APPEND, 8'hA5, 8'hFF);
    send_beat(FUNC_APPEND, 8'h00, 8'h00);
    send_beat(FUNC_APPEND, 8'h80, 8'hF0);
    send_beat(FUNC_DATA, 8'h11, 8'h00);
    send_beat(FUNC_DATA, 8'hA5, 8'h00);
    send_beat(FUNC_DATA, 8'h37, 8'hFF);
    send_beat(FUNC_DATA, 8'h8C, 8'h00);
    send_beat(FUNC_DATA, 8'hA5, 8'h00);
    send_beat(FUNC_DATA, 8'hFF, 8'h00);
    send_beat(FUNC_DATA, 8'h8F, 8'h00);
    send_beat(FUNC_CLEAR, 8'h00, 8'h00);
    send_beat(FUNC_RESTART, 8'h00, 8'h00);
    send_beat(FUNC_APPEND, 8'h0F, 8'hF0);
    send_beat(FUNC_DATA, 8'h0F, 8'h00);
    send_beat(FUNC_DATA, 8'hFF, 8'h00);
    send_beat(FUNC_DATA, 8'h00, 8'h00);
  endtask

  // Stale window bytes must not count after a restart; clear keeps the scan state.
  task automatic test_short_history();
    send_beat(FUNC_CLEAR, 8'h00, 8'h00);
    repeat (3) send_beat(FUNC_APPEND, 8'h00, 8'h00);
    send_beat(FUNC_RESTART, 8'h00, 8'h00);
    send_beat(FUNC_DATA, 8'h12, 8'h00);
    send_beat(FUNC_DATA, 8'h34, 8'h00);
    send_beat(FUNC_DATA, 8'h56, 8'h00);
    send_beat(FUNC_DATA, 8'h78, 8'h00);
    send_beat(FUNC_CLEAR, 8'h00, 8'h00);
    send_beat(FUNC_DATA, 8'h9A, 8'h00);
  endtask

  // Fill all pattern slots, then two refused appends, then a match on the full window.
  task automatic test_full_store();
    send_beat(FUNC_CLEAR, 8'h00, 8'h00);
    for (int i = 0; i < PAT_DEPTH - 1; i++) send_beat(FUNC_APPEND, 8'h00, 8'h00);
    send_beat(FUNC_APPEND, 8'hFF, 8'hFF);
    send_beat(FUNC_APPEND, 8'hFF, 8'hFF);
    send_beat(FUNC_APPEND, 8'h00, 8'h00);
    send_beat(FUNC_RESTART, 8'h00, 8'h00);
    for (int i = 0; i < PAT_DEPTH + 6; i++)
      send_beat(FUNC_DATA, (i == 40 || i == 66) ? 8'hFF : byte_t'($urandom_range(0, 254)),
                8'h00);
    send_beat(FUNC_APPEND, 8'h01, 8'h01);
  endtask

  // Hold the output for a long stretch while input keeps coming at full rate.
  task automatic test_output_stall();
    send_beat(FUNC_CLEAR, 8'h00, 8'h00);
    send_beat(FUNC_APPEND, 8'h40, 8'hC0);
    send_beat(FUNC_APPEND, 8'h01, 8'h01);
    sender_idle_on = 1'b0;
    hold_request = 60;
    repeat (40) send_beat(FUNC_DATA, byte_t'($urandom), byte_t'($urandom));
    sender_idle_on = 1'b1;
    wait_for_drain();
    repeat (30) send_beat(FUNC_DATA, byte_t'($urandom), 8'h00);
  endtask

  // No idling on either side.
  task automatic test_full_rate();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    send_beat(FUNC_RESTART, 8'h00, 8'h00);
    send_beat(FUNC_CLEAR, 8'h00, 8'h00);
    send_beat(FUNC_APPEND, 8'h3C, 8'h3C);
    repeat (40) send_beat(FUNC_DATA, byte_t'($urandom), 8'h00);
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
  endtask

  // Mostly load-then-scan sequences with planted pattern copies, some noise.
  task automatic test_random_traffic(input int unsigned goal);
    int unsigned first;
    int unsigned len;
    int unsigned n;
    int unsigned r;
    byte_t v;
    byte_t m;
    byte_t lv[$];
    byte_t lm[$];
    first = items_sent;
    while (items_sent - first < goal) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6))
          send_beat(func_t'($urandom_range(0, 3)), byte_t'($urandom), byte_t'($urandom));
        lv.delete();
        lm.delete();
      end else begin
        if ($urandom_range(0, 3) == 0) send_beat(FUNC_RESTART, byte_t'($urandom), 8'h00);
        if (lv.size() == 0 || $urandom_range(0, 2) != 0) begin
          send_beat(FUNC_CLEAR, byte_t'($urandom), byte_t'($urandom));
          lv.delete();
          lm.delete();
          r = $urandom_range(0, 99);
          len = (r < 50) ? $urandom_range(1, 3) : (r < 90) ? $urandom_range(4, 8) :
                (r < 97) ? $urandom_range(9, 20) : $urandom_range(60, 68);
          repeat (len) begin
            m = byte_t'($urandom);
            v = ($urandom_range(0, 9) == 0) ? byte_t'($urandom) : (byte_t'($urandom) & m);
            send_beat(FUNC_APPEND, v, m);
            if (lv.size() < PAT_DEPTH) begin
              lv.push_back(v);
              lm.push_back(m);
            end
          end
        end
        n = $urandom_range(4, 24);
        while (n > 0) begin
          if (lv.size() > 0 && $urandom_range(0, 2) == 0) begin
            // plant one copy, free bits random
            foreach (lv[i]) send_beat(FUNC_DATA, lv[i] | (byte_t'($urandom) & ~lm[i]), 8'h00);
          end else begin
            send_beat(FUNC_DATA, byte_t'($urandom), byte_t'($urandom));
          end
          n--;
        end
      end
    end
  endtask

  initial begin
    #5000000;
    $display("[masked_byte_pattern_search_core] ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.func       <= FUNC_CLEAR;
    item_ch.byte_value <= '0;
    item_ch.byte_mask  <= '0;
    pat_len    = 0;
    scan_count = '0;
    hit_seen   = 1'b0;
    hit_offset = '0;
    foreach (recent[i]) recent[i] = '0;
    hold_request     = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_pattern();
    test_masked_compare();
    test_short_history();
    test_full_store();
    test_output_stall();
    test_full_rate();
    test_random_traffic(120);

    wait_for_drain();
    repeat (10) @(negedge clk);
    $display("sent %0d items, checked %0d result beats (%0d matches, %0d refused appends)",
             items_sent, beats_checked, match_beats, overflow_beats);
    $display("covered masks, short history, full store, long output stall, full rate");
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[masked_byte_pattern_search_core] OK");
    else
      $display("[masked_byte_pattern_search_core] ERROR");
    $finish;
  end

endmodule
